FILE: hdl/kvi_pkg.sv
package kvi_pkg;

    // item command codes
    localparam logic CMD_PARAM  = 1'b0;
    localparam logic CMD_VERTEX = 1'b1;

    // register index on the configuration port (paddr[2])
    localparam logic REG_LERP_WEIGHT = 1'b0;

    localparam int AXIS_COUNT           = 3;
    localparam int AXIS_SLOTS           = 6;
    localparam int NORMAL_TABLE_ENTRIES = 162;
    localparam logic [7:0] NORMAL_LAST  = 8'(NORMAL_TABLE_ENTRIES - 1);

    localparam logic [16:0] WEIGHT_ONE = 17'h10000;

    // saturation bounds of the blended position
    localparam logic signed [45:0] POS_MAX = 46'sd2147483647;
    localparam logic signed [45:0] POS_MIN = -46'sd2147483648;

    // stage advance enables, one per register stage
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
    } t_pipe_en;

    // unit normals scaled by 127, packed as {x, y, z}
    localparam logic [23:0] NORMAL_TABLE [NORMAL_TABLE_ENTRIES] = '{
    24'hbd006c,24'hc81e6e,24'hdb0079,24'hd94067,24'heb2179,24'h00007f,24'h006c43,24'hed5b57,
    24'h135b57,24'h00436c,24'h274067,24'h43006c,24'h250079,24'h381e6e,24'h152179,24'ha9135b,
    24'h992740,24'hb53657,24'h944300,24'h92381e,24'ha55713,24'ha94b36,24'hc06727,24'he26e38,
    24'hca574b,24'ha557ed,24'hc067d9,24'hbd6c00,24'h006cbd,24'he26ec8,24'h0079db,24'hdf79eb,
    24'h007f00,24'h007925,24'hdf7915,24'h1e6e38,24'h217915,24'h406727,24'h1e6ec8,24'h2179eb,
    24'h4067d9,24'h6c4300,24'h5b5713,24'h5b57ed,24'h436c00,24'h36574b,24'h6e381e,24'h574b36,
    24'h672740,24'h57135b,24'h4b3657,24'h792500,24'h7f0000,24'h791521,24'h6cbd00,24'h79db00,
    24'h6ec81e,24'h79eb21,24'h67d940,24'h57ed5b,24'h6c0043,24'h6e38e2,24'h6727c0,24'h7915df,
    24'h430094,24'h5713a5,24'h57eda5,24'h6c00bd,24'h67d9c0,24'h6ec8e2,24'h79ebdf,24'h135ba9,
    24'h274099,24'h3657b5,24'h381e92,24'h4b36a9,24'h574bca,24'hed5ba9,24'hd94099,24'h004394,
    24'hbd0094,24'hc81e92,24'hdb0087,24'heb2187,24'h000081,24'h250087,24'h152187,24'hc8e292,
    24'hd9c099,24'hebdf87,24'h0094bd,24'heda5a9,24'h13a5a9,24'h00bd94,24'h27c099,24'h38e292,
    24'h15df87,24'h1e92c8,24'h4099d9,24'h36a9b5,24'h5ba9ed,24'h57b5ca,24'h4bcaa9,24'h0087db,
    24'h008100,24'h2187eb,24'h009443,24'h008725,24'h1e9238,24'h218715,24'h409927,24'h5ba913,
    24'h439400,24'he292c8,24'hc099d9,24'hdf87eb,24'h94bd00,24'ha5a9ed,24'ha5a913,24'hbd9400,
    24'hc09927,24'he29238,24'hdf8715,24'h92c81e,24'h99d940,24'ha9b536,24'ha9ed5b,24'hc8e26e,
    24'hb5ca57,24'hd9c067,24'heda557,24'hcaa94b,24'hebdf79,24'h38e26e,24'h15df79,24'h27c067,
    24'h13a557,24'h00bd6c,24'h36a94b,24'h4bca57,24'h57b536,24'h872500,24'h871521,24'h810000,
    24'h940043,24'h87db00,24'h87eb21,24'h9238e2,24'h8715df,24'h9927c0,24'h92c8e2,24'h87ebdf,
    24'h99d9c0,24'ha913a5,24'ha9eda5,24'h9400bd,24'ha94bca,24'hb536a9,24'hca57b5,24'hcaa9b5,
    24'hb5caa9,24'ha9b5ca
    };

    // table read, zero for an index past the end
    function automatic logic [23:0] kvi_normal(input logic [7:0] idx);
        logic [23:0] ent;
        ent = 24'h000000;
        if (idx <= NORMAL_LAST) begin
            ent = NORMAL_TABLE[idx];
        end
        return ent;
    endfunction

endpackage

FILE: hdl/kvi_regs.sv
module kvi_regs
    import kvi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // parameter load from the item stream
    input  logic               i_param_we,
    input  logic [2:0]         i_param_slot,
    input  logic [31:0]        i_param_scale,
    input  logic signed [31:0] i_param_translate,
    // current values
    output logic [31:0]        o_scale [AXIS_SLOTS],
    output logic signed [31:0] o_translate [AXIS_SLOTS],
    output logic [16:0]        o_weight
);

    logic [16:0]        r_weight;
    logic [31:0]        r_scale [AXIS_SLOTS];
    logic signed [31:0] r_translate [AXIS_SLOTS];

    assign pready = 1'b1;

    // register read back
    always_comb begin
        prdata = 32'h0000_0000;
        if (paddr[2] == REG_LERP_WEIGHT) begin
            prdata = {15'h0000, r_weight};
        end
    end

    // weight register, written on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= 17'h00000;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_LERP_WEIGHT) begin
            r_weight <= pwdata[16:0];
        end
    end

    // axis parameter slots, slots six and seven are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < AXIS_SLOTS; s++) begin
                r_scale[s]     <= 32'h0000_0000;
                r_translate[s] <= 32'sh0000_0000;
            end
        end else if (i_param_we) begin
            for (int s = 0; s < AXIS_SLOTS; s++) begin
                if (i_param_slot == 3'(s)) begin
                    r_scale[s]     <= i_param_scale;
                    r_translate[s] <= i_param_translate;
                end
            end
        end
    end

    assign o_scale     = r_scale;
    assign o_translate = r_translate;

    // weights above one act as one
    assign o_weight = r_weight[16] ? WEIGHT_ONE : r_weight;

endmodule

FILE: hdl/kvi_axis_lane.sv
module kvi_axis_lane
    import kvi_pkg::*;
(
    input  logic               i_clk,
    input  t_pipe_en           i_en,
    input  logic [7:0]         i_byte_a,
    input  logic [7:0]         i_byte_b,
    input  logic [31:0]        i_scale_a,
    input  logic signed [31:0] i_translate_a,
    input  logic [31:0]        i_scale_b,
    input  logic signed [31:0] i_translate_b,
    input  logic [16:0]        i_weight,
    output logic signed [31:0] o_pos
);

    // stage 1: captured vertex bytes and the parameters in force
    logic [7:0]         r_byte_a, r_byte_b;
    logic [31:0]        r_scale_a, r_scale_b;
    logic signed [31:0] r_trn_a, r_trn_b;
    // stage 2: decoded positions
    logic signed [41:0] r_pa2, r_pb2;
    // stage 3: weighted difference
    logic signed [41:0] r_pa3;
    logic signed [60:0] r_scaled;
    // stage 4: saturated result
    logic signed [31:0] r_pos;

    logic [39:0]        w_prod_a, w_prod_b;
    logic signed [41:0] n_pa2, n_pb2;
    logic signed [42:0] w_diff;
    logic signed [17:0] w_wt;
    logic signed [60:0] n_scaled;
    logic signed [44:0] w_frac;
    logic signed [45:0] w_blend;
    logic signed [31:0] n_pos;

    // decode: byte times scale plus translate
    assign w_prod_a = 40'(r_byte_a) * 40'(r_scale_a);
    assign w_prod_b = 40'(r_byte_b) * 40'(r_scale_b);
    assign n_pa2    = $signed({2'b00, w_prod_a}) + 42'(r_trn_a);
    assign n_pb2    = $signed({2'b00, w_prod_b}) + 42'(r_trn_b);

    // blend product (b - a) * w
    assign w_diff   = 43'(r_pb2) - 43'(r_pa2);
    assign w_wt     = $signed({1'b0, i_weight});
    assign n_scaled = 61'(w_diff) * 61'(w_wt);

    // floor of the Q0.16 product, add and saturate
    assign w_frac  = 45'(r_scaled >>> 16);
    assign w_blend = 46'(r_pa3) + 46'(w_frac);

    always_comb begin
        n_pos = w_blend[31:0];
        if (w_blend > POS_MAX) begin
            n_pos = 32'sh7fff_ffff;
        end else if (w_blend < POS_MIN) begin
            n_pos = 32'sh8000_0000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en1) begin
            r_byte_a  <= i_byte_a;
            r_byte_b  <= i_byte_b;
            r_scale_a <= i_scale_a;
            r_scale_b <= i_scale_b;
            r_trn_a   <= i_translate_a;
            r_trn_b   <= i_translate_b;
        end
        if (i_en.en2) begin
            r_pa2 <= n_pa2;
            r_pb2 <= n_pb2;
        end
        if (i_en.en3) begin
            r_pa3    <= r_pa2;
            r_scaled <= n_scaled;
        end
        if (i_en.en4) begin
            r_pos <= n_pos;
        end
    end

    assign o_pos = r_pos;

endmodule

FILE: hdl/kvi_normal_lane.sv
module kvi_normal_lane
    import kvi_pkg::*;
(
    input  logic              i_clk,
    input  t_pipe_en          i_en,
    input  logic [7:0]        i_idx_a,
    input  logic [7:0]        i_idx_b,
    input  logic [16:0]       i_weight,
    output logic signed [7:0] o_norm [AXIS_COUNT],
    output logic              o_bad
);

    // stage 1: indices
    logic [7:0]         r_idx_a, r_idx_b;
    // stage 2: table entries
    logic [23:0]        r_ent_a, r_ent_b;
    logic               r_bad2;
    // stage 3: frame A component and weighted difference
    logic signed [7:0]  r_ca [AXIS_COUNT];
    logic signed [15:0] r_prod [AXIS_COUNT];
    logic               r_bad3;
    // stage 4: result
    logic signed [7:0]  r_norm [AXIS_COUNT];
    logic               r_bad4;

    logic signed [7:0]  w_ca [AXIS_COUNT];
    logic signed [7:0]  w_cb [AXIS_COUNT];
    logic signed [15:0] n_prod [AXIS_COUNT];
    logic signed [7:0]  n_norm [AXIS_COUNT];
    logic signed [7:0]  w_w6;

    // seven-bit weight, 0 to 64
    assign w_w6 = $signed({1'b0, i_weight[16:10]});

    // per-axis difference times weight
    always_comb begin
        for (int k = 0; k < AXIS_COUNT; k++) begin
            w_ca[k]   = $signed(r_ent_a[23 - 8 * k -: 8]);
            w_cb[k]   = $signed(r_ent_b[23 - 8 * k -: 8]);
            n_prod[k] = 16'(9'(w_cb[k]) - 9'(w_ca[k])) * 16'(w_w6);
        end
    end

    // add the floored fraction, bad index forces zero
    always_comb begin
        for (int k = 0; k < AXIS_COUNT; k++) begin
            n_norm[k] = r_ca[k] + 8'(r_prod[k] >>> 6);
            if (r_bad3) begin
                n_norm[k] = 8'sh00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en1) begin
            r_idx_a <= i_idx_a;
            r_idx_b <= i_idx_b;
        end
        if (i_en.en2) begin
            r_ent_a <= kvi_normal(r_idx_a);
            r_ent_b <= kvi_normal(r_idx_b);
            r_bad2  <= (r_idx_a > NORMAL_LAST) || (r_idx_b > NORMAL_LAST);
        end
        if (i_en.en3) begin
            r_ca   <= w_ca;
            r_prod <= n_prod;
            r_bad3 <= r_bad2;
        end
        if (i_en.en4) begin
            r_norm <= n_norm;
            r_bad4 <= r_bad3;
        end
    end

    assign o_norm = r_norm;
    assign o_bad  = r_bad4;

endmodule

FILE: hdl/keyframe_vertex_interpolator.sv
// Keyframe vertex interpolator: decodes byte-compressed vertices of two
// keyframes and blends them into Q16.16 positions and 8-bit normals.
// Input channel (i_in_valid / o_in_stall): a transfer with command 0 loads
// scale and translate of one axis slot and gives no result; command 1
// carries one vertex and gives exactly one result transfer.
// Output channel (o_out_valid / i_out_stall): positions, normals and the
// bad-normal flag of one vertex per transfer, in input order.
// lerp_weight sits at byte address 0 of the APB port; pready is always high.
// The result is valid once the vertex reaches the last register stage and, with no
// output stall, transfers right away.
// One vertex is taken per cycle while o_in_stall is low: four register stages
// (capture, byte times scale decode, 43x18 blend multiply, add and saturate)
// each advance whenever the stage after them is empty or moving.
// A parameter load takes effect for the vertex in the next transfer.
// When the receiver stalls, results hold in place and the stages fill up;
// o_in_stall rises only once all four stages hold a vertex.
// Reset (synchronous, active low) empties the pipeline and clears the weight
// and all six axis slots to zero.
module keyframe_vertex_interpolator
    import kvi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_command,
    input  logic [2:0]         i_param_slot,
    input  logic [31:0]        i_scale,
    input  logic signed [31:0] i_translate,
    input  logic [7:0]         i_a_x,
    input  logic [7:0]         i_a_y,
    input  logic [7:0]         i_a_z,
    input  logic [7:0]         i_a_normal,
    input  logic [7:0]         i_b_x,
    input  logic [7:0]         i_b_y,
    input  logic [7:0]         i_b_z,
    input  logic [7:0]         i_b_normal,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [7:0]  o_norm_x,
    output logic signed [7:0]  o_norm_y,
    output logic signed [7:0]  o_norm_z,
    output logic               o_normal_bad
);

    logic               r_v1, r_v2, r_v3, r_v4;
    t_pipe_en           w_en;
    logic               w_accept;
    logic [31:0]        w_scale [AXIS_SLOTS];
    logic signed [31:0] w_translate [AXIS_SLOTS];
    logic [16:0]        w_weight;
    logic [7:0]         w_byte_a [AXIS_COUNT];
    logic [7:0]         w_byte_b [AXIS_COUNT];
    logic signed [31:0] w_pos [AXIS_COUNT];
    logic signed [7:0]  w_norm [AXIS_COUNT];

    // stage advance: a stage moves when it is empty or the next one moves
    assign w_en.en4  = !r_v4 || !i_out_stall;
    assign w_en.en3  = !r_v3 || w_en.en4;
    assign w_en.en2  = !r_v2 || w_en.en3;
    assign w_en.en1  = !r_v1 || w_en.en2;
    assign o_in_stall = !w_en.en1;
    assign w_accept   = i_in_valid && w_en.en1;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en.en1) begin
                r_v1 <= w_accept && (i_command == CMD_VERTEX);
            end
            if (w_en.en2) begin
                r_v2 <= r_v1;
            end
            if (w_en.en3) begin
                r_v3 <= r_v2;
            end
            if (w_en.en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    kvi_regs u_regs (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_param_we        (w_accept && (i_command == CMD_PARAM)),
        .i_param_slot      (i_param_slot),
        .i_param_scale     (i_scale),
        .i_param_translate (i_translate),
        .o_scale           (w_scale),
        .o_translate       (w_translate),
        .o_weight          (w_weight)
    );

    assign w_byte_a[0] = i_a_x;
    assign w_byte_a[1] = i_a_y;
    assign w_byte_a[2] = i_a_z;
    assign w_byte_b[0] = i_b_x;
    assign w_byte_b[1] = i_b_y;
    assign w_byte_b[2] = i_b_z;

    // one position lane per axis, frame B slots follow the frame A slots
    for (genvar k = 0; k < AXIS_COUNT; k++) begin : g_axis
        kvi_axis_lane u_axis (
            .i_clk         (i_clk),
            .i_en          (w_en),
            .i_byte_a      (w_byte_a[k]),
            .i_byte_b      (w_byte_b[k]),
            .i_scale_a     (w_scale[k]),
            .i_translate_a (w_translate[k]),
            .i_scale_b     (w_scale[k + AXIS_COUNT]),
            .i_translate_b (w_translate[k + AXIS_COUNT]),
            .i_weight      (w_weight),
            .o_pos         (w_pos[k])
        );
    end

    kvi_normal_lane u_normal (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_idx_a  (i_a_normal),
        .i_idx_b  (i_b_normal),
        .i_weight (w_weight),
        .o_norm   (w_norm),
        .o_bad    (o_normal_bad)
    );

    assign o_out_valid = r_v4;
    assign o_pos_x     = w_pos[0];
    assign o_pos_y     = w_pos[1];
    assign o_pos_z     = w_pos[2];
    assign o_norm_x    = w_norm[0];
    assign o_norm_y    = w_norm[1];
    assign o_norm_z    = w_norm[2];

    // a parameter load never enters the pipeline
    a_param_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_command == CMD_PARAM) |=> !r_v1)
        else $error("parameter load entered the pipeline");

    // an accepted vertex occupies stage one next cycle
    a_vertex_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_command == CMD_VERTEX) |=> r_v1)
        else $error("accepted vertex lost at stage one");

    // input stalls only when every stage is full and the output is held
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && i_out_stall))
        else $error("input stalled with a free stage");

    // a bad normal index gives a zero normal
    a_bad_normal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_normal_bad) |->
            (o_norm_x == 8'sh00 && o_norm_y == 8'sh00 && o_norm_z == 8'sh00))
        else $error("bad normal index with nonzero normal");

endmodule
